@@ src/rdc_pkg.sv @@
// Shared types, constants and the digit-to-ASCII function for the radix converter.
package rdc_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int BASE_W  = 8;

    localparam logic [BASE_W-1:0]  BASE_MIN     = 8'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX     = 8'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE    = 7'd57;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_Z = 7'd122;
    localparam logic [CHAR_W-1:0]  CHAR_ERR     = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_READ,
        ST_SHOW
    } rdc_state_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_LOWER_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ src/rdc_divider.sv @@
// Bit-serial restoring divider: value by a 6-bit base, one quotient bit per cycle.
module rdc_divider
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIGIT_W-1:0]    divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder
);

    localparam int CW = $clog2(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [DIGIT_W-1:0]    div_reg, div_next;
    logic [DIGIT_W:0]      trial;
    logic                  fits;

    // partial remainder stays below the divisor, so it fits back into 6 bits
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DIGIT_W'(trial - {1'b0, div_reg}) : trial[DIGIT_W-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/rdc_digit_buf.sv @@
// Digit store: remainders written in order of discovery, read back with a registered port.
module rdc_digit_buf
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(VALUE_BITS)-1:0] wr_addr,
    input  logic [DIGIT_W-1:0]            wr_data,
    input  logic [$clog2(VALUE_BITS)-1:0] rd_addr,
    output logic [DIGIT_W-1:0]            rd_data
);

    logic [DIGIT_W-1:0] mem [0:VALUE_BITS-1];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/radix_digit_converter.sv @@
// Radix converter: unsigned value to ASCII digits in base 2..36, most significant first.
// Each digit costs a pass through the shared bit-serial divider; once all digits are
// found, each digit word goes out by a buffer read, then the output.
// One number at a time: s_ready is high only while idle. A bad base answers in 1 word.
// aresetn is synchronous, active low, and returns the sequencer to idle.
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_value,
    input  logic [BASE_W-1:0] s_base,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_digit_char,
    output logic              m_last,
    output logic              m_bad_base
);

    localparam int AW = $clog2(VALUE_BITS);

    rdc_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [DIGIT_W-1:0]    base_reg, base_next;
    logic [AW-1:0]         wr_idx_reg, wr_idx_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;

    logic                  in_fire;
    logic                  base_ok;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [DIGIT_W-1:0]    div_rem;
    logic                  buf_we;
    logic [DIGIT_W-1:0]    buf_rd;
    logic                  rd_first;

    assign in_fire  = s_valid && s_ready;
    assign base_ok  = (s_base >= BASE_MIN) && (s_base <= BASE_MAX);
    assign rd_first = (rd_idx_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = base_ok ? ST_DIV_START : ST_ERR;
                end
            end
            ST_ERR: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (div_quo == '0) ? ST_READ : ST_DIV_START;
                end
            end
            ST_READ: state_next = ST_SHOW;
            ST_SHOW: begin
                if (m_ready) begin
                    state_next = rd_first ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        m_digit_char = CHAR_ERR;
        m_last       = 1'b0;
        m_bad_base   = 1'b0;
        div_start    = 1'b0;
        buf_we       = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_ERR: begin
                m_valid    = 1'b1;
                m_last     = 1'b1;
                m_bad_base = 1'b1;
            end
            ST_DIV_START: div_start = 1'b1;
            ST_DIV_WAIT:  buf_we    = div_done;
            ST_SHOW: begin
                m_valid      = 1'b1;
                m_digit_char = digit_ascii(buf_rd);
                m_last       = rd_first;
            end
            default: ;
        endcase
    end

    always_comb begin
        value_next  = value_reg;
        base_next   = base_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (in_fire) begin
            value_next  = VALUE_BITS'(s_value);
            base_next   = s_base[DIGIT_W-1:0];
            wr_idx_next = '0;
        end
        if (buf_we) begin
            value_next  = div_quo;
            wr_idx_next = wr_idx_reg + AW'(1);
            // most significant digit is the one just written
            rd_idx_next = wr_idx_reg;
        end
        if (state_reg == ST_SHOW && m_ready && !rd_first) begin
            rd_idx_next = rd_idx_reg - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        value_reg  <= value_next;
        base_reg   <= base_next;
        wr_idx_reg <= wr_idx_next;
        rd_idx_reg <= rd_idx_next;
    end

    rdc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (value_reg),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rdc_digit_buf #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit_buf (
        .aclk    (aclk),
        .wr_en   (buf_we),
        .wr_addr (wr_idx_reg),
        .wr_data (div_rem),
        .rd_addr (rd_idx_reg),
        .rd_data (buf_rd)
    );

endmodule

@@ src/rdc_checker.sv @@
// Port-level checks for the radix converter, bound to the top level.
module rdc_checker
    import rdc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAR_W-1:0] m_digit_char,
    input logic              m_last,
    input logic              m_bad_base
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char)
                                && $stable(m_last) && $stable(m_bad_base))
        else $error("result word changed while stalled");

    // one number at a time: no intake while a word is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again straight after taking a word");

    a_bad_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_base |-> m_last && (m_digit_char == CHAR_ERR))
        else $error("bad base word malformed");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_base |->
            ((m_digit_char >= CHAR_ZERO) && (m_digit_char <= CHAR_NINE)) ||
            ((m_digit_char >= CHAR_LOWER_A) && (m_digit_char <= CHAR_LOWER_Z)))
        else $error("digit character out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
